// File: hw/rtl/time_string_to_hundredths_assert.svh
// Assertion macros for the time text parser RTL.
`ifndef TIME_STRING_TO_HUNDREDTHS_ASSERT_SVH
`define TIME_STRING_TO_HUNDREDTHS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tsh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tsh assertion failed");

`endif

// File: hw/rtl/tsh_pkg.sv
// Types and constants for the time text parser.
package tsh_pkg;

    localparam int VALUE_W = 30;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam logic [2:0] PREFIX_LEN = 3'd4;
    localparam logic [2:0] NO_PREFIX  = 3'd5;

    localparam logic [1:0] FIELD_MIN  = 2'd0;
    localparam logic [1:0] FIELD_SEC  = 2'd1;
    localparam logic [1:0] FIELD_HUND = 2'd2;
    localparam logic [1:0] FIELD_DONE = 2'd3;

    localparam logic [6:0] SEC_SAT  = 7'd60;
    localparam logic [6:0] SEC_MAX  = 7'd59;
    localparam logic [6:0] HUND_SAT = 7'd100;
    localparam logic [6:0] HUND_MAX = 7'd99;

    localparam int MIN_TO_HUND = 6000;
    localparam int SEC_TO_HUND = 100;

    typedef enum logic [1:0] {
        KIND_TIME     = 2'd0,
        KIND_FROM_END = 2'd1,
        KIND_END_MARK = 2'd2,
        KIND_INVALID  = 2'd3
    } result_kind_t;

    // Finished parse handed from the scanner to the arithmetic stage
    typedef struct packed {
        result_kind_t kind;
        logic [5:0]   seconds;
        logic [9:0]   hundredths;
    } tsh_job_t;

    // Characters of the "EOF-" prefix
    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h45;
            2'd1:    ch = 8'h4F;
            2'd2:    ch = 8'h46;
            default: ch = 8'h2D;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/tsh_scan.sv
// Per-character parser state and the finished-parse register.
module tsh_scan #(
    parameter int MINUTE_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_text_char,
    input  logic                    s_last_char,
    output logic                    job_valid,
    input  logic                    calc_ready,
    output tsh_pkg::tsh_job_t       job,
    output logic [MINUTE_BITS-1:0]  job_minutes
);
    import tsh_pkg::*;

    localparam int MIN_W  = MINUTE_BITS + 1;
    localparam int PROD_W = MINUTE_BITS + 5;
    localparam logic [PROD_W-1:0] MIN_LIMIT = PROD_W'(1) << MINUTE_BITS;

    logic [2:0]        prefix_reg, prefix_next;
    logic              from_end_reg, from_end_next;
    logic [1:0]        field_reg, field_next;
    logic              has_digit_reg, has_digit_next;
    logic [1:0]        matched_reg, matched_next;
    logic [MIN_W-1:0]  minutes_reg, minutes_next;
    logic [6:0]        seconds_reg, seconds_next;
    logic [6:0]        hund_reg, hund_next;
    logic              bad_reg, bad_next;
    logic [3:0]        count_reg, count_next;
    logic [1:0]        dots_reg, dots_next;
    logic              job_valid_reg, job_valid_next;
    tsh_job_t          job_reg, job_next;
    logic [MINUTE_BITS-1:0] job_min_reg, job_min_next;

    logic              s_fire;
    logic              is_digit;
    logic              is_dot;
    logic [3:0]        digit;
    logic [PROD_W-1:0] min_prod;
    logic [MIN_W-1:0]  min_sat;
    logic [9:0]        sec_prod;
    logic [9:0]        hund_prod;
    logic [6:0]        sec_sat;
    logic [6:0]        hund_sat;

    assign s_ready     = !job_valid_reg || calc_ready;
    assign s_fire      = s_valid && s_ready;
    assign job_valid   = job_valid_reg;
    assign job         = job_reg;
    assign job_minutes = job_min_reg;

    assign is_digit = (s_text_char >= CHAR_ZERO) && (s_text_char <= CHAR_NINE);
    assign is_dot   = (s_text_char == CHAR_DOT);
    assign digit    = s_text_char[3:0];

    // Decimal accumulate with saturation, one digit per transfer
    assign min_prod  = PROD_W'(minutes_reg) * PROD_W'(10) + PROD_W'(digit);
    assign min_sat   = (min_prod > MIN_LIMIT) ? MIN_LIMIT[MIN_W-1:0] : min_prod[MIN_W-1:0];
    assign sec_prod  = 10'(seconds_reg) * 10'd10 + 10'(digit);
    assign hund_prod = 10'(hund_reg) * 10'd10 + 10'(digit);
    assign sec_sat   = (sec_prod > 10'(SEC_SAT)) ? SEC_SAT : sec_prod[6:0];
    assign hund_sat  = (hund_prod > 10'(HUND_SAT)) ? HUND_SAT : hund_prod[6:0];

    always_comb begin
        logic scan_en;
        logic invalid;
        prefix_next    = prefix_reg;
        from_end_next  = from_end_reg;
        field_next     = field_reg;
        has_digit_next = has_digit_reg;
        matched_next   = matched_reg;
        minutes_next   = minutes_reg;
        seconds_next   = seconds_reg;
        hund_next      = hund_reg;
        bad_next       = bad_reg;
        count_next     = count_reg;
        dots_next      = dots_reg;
        job_next       = job_reg;
        job_min_next   = job_min_reg;
        job_valid_next = job_valid_reg && !calc_ready;
        scan_en        = 1'b0;
        invalid        = 1'b0;

        if (s_fire) begin
            scan_en = 1'b1;
            if (prefix_reg < PREFIX_LEN) begin
                if (s_text_char == prefix_char(prefix_reg[1:0])) begin
                    prefix_next = prefix_reg + 3'd1;
                    scan_en     = 1'b0;
                    if (prefix_reg == PREFIX_LEN - 3'd1) begin
                        from_end_next = 1'b1;
                    end
                end else begin
                    // a started prefix that departs from "EOF-" spoils the text
                    if (prefix_reg != 3'd0) begin
                        bad_next = 1'b1;
                    end
                    prefix_next = NO_PREFIX;
                end
            end

            if (scan_en) begin
                if (count_reg != 4'hF) begin
                    count_next = count_reg + 4'd1;
                end
                dots_next = {dots_reg[0], is_dot};
                if (!is_digit && !is_dot) begin
                    bad_next = 1'b1;
                end else if (field_reg != FIELD_DONE) begin
                    if (is_digit) begin
                        if (!has_digit_reg) begin
                            has_digit_next = 1'b1;
                            if (matched_reg != 2'd3) begin
                                matched_next = matched_reg + 2'd1;
                            end
                        end
                        case (field_reg)
                            FIELD_MIN: minutes_next = min_sat;
                            FIELD_SEC: seconds_next = sec_sat;
                            default:   hund_next    = hund_sat;
                        endcase
                    end else if (has_digit_reg && field_reg < FIELD_HUND) begin
                        field_next     = field_reg + 2'd1;
                        has_digit_next = 1'b0;
                    end else begin
                        field_next = FIELD_DONE;
                    end
                end
            end

            if (s_last_char) begin
                job_valid_next     = 1'b1;
                job_next.seconds   = seconds_next[5:0];
                job_next.hundredths = 10'(hund_next);
                job_min_next       = minutes_next[MINUTE_BITS-1:0];
                if (!scan_en) begin
                    // text ended inside the prefix: only "EOF" is meaningful
                    job_next.kind = (prefix_next == 3'd3) ? KIND_END_MARK : KIND_INVALID;
                end else begin
                    invalid = bad_next || (matched_next < 2'd2) ||
                              (seconds_next > SEC_MAX) || (hund_next > HUND_MAX) ||
                              minutes_next[MINUTE_BITS];
                    if (invalid) begin
                        job_next.kind = KIND_INVALID;
                    end else begin
                        job_next.kind = from_end_next ? KIND_FROM_END : KIND_TIME;
                    end
                    // a dot just before the last digit means tenths
                    if (count_next >= 4'd2 && dots_next[1]) begin
                        job_next.hundredths = 10'(hund_next) * 10'd10;
                    end
                end
                prefix_next    = 3'd0;
                from_end_next  = 1'b0;
                field_next     = FIELD_MIN;
                has_digit_next = 1'b0;
                matched_next   = 2'd0;
                minutes_next   = '0;
                seconds_next   = 7'd0;
                hund_next      = 7'd0;
                bad_next       = 1'b0;
                count_next     = 4'd0;
                dots_next      = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg    <= 3'd0;
            from_end_reg  <= 1'b0;
            field_reg     <= FIELD_MIN;
            has_digit_reg <= 1'b0;
            matched_reg   <= 2'd0;
            minutes_reg   <= '0;
            seconds_reg   <= 7'd0;
            hund_reg      <= 7'd0;
            bad_reg       <= 1'b0;
            count_reg     <= 4'd0;
            dots_reg      <= 2'd0;
            job_valid_reg <= 1'b0;
        end else begin
            prefix_reg    <= prefix_next;
            from_end_reg  <= from_end_next;
            field_reg     <= field_next;
            has_digit_reg <= has_digit_next;
            matched_reg   <= matched_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            hund_reg      <= hund_next;
            bad_reg       <= bad_next;
            count_reg     <= count_next;
            dots_reg      <= dots_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        job_min_reg <= job_min_next;
    end

endmodule

// File: hw/rtl/tsh_calc.sv
// Total in hundredths from a finished parse, into the result register.
module tsh_calc #(
    parameter int MINUTE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    output logic                          calc_ready,
    input  tsh_pkg::tsh_job_t             job,
    input  logic [MINUTE_BITS-1:0]        job_minutes,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [tsh_pkg::VALUE_W-1:0] m_time_value,
    output logic [1:0]                    m_result_kind
);
    import tsh_pkg::*;

    localparam int SUM_W = (MINUTE_BITS + 14 > VALUE_W) ? MINUTE_BITS + 14 : VALUE_W;

    logic                      m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    result_kind_t              kind_reg, kind_next;
    logic [SUM_W-1:0]          total;
    logic [SUM_W-1:0]          signed_total;
    logic                      job_fire;

    assign calc_ready = !m_valid_reg || m_ready;
    assign job_fire   = job_valid && calc_ready;

    assign total = SUM_W'(job_minutes) * SUM_W'(MIN_TO_HUND) +
                   SUM_W'(job.seconds) * SUM_W'(SEC_TO_HUND) +
                   SUM_W'(job.hundredths);
    // low bits of the wide negation equal the negation modulo the output width
    assign signed_total = (job.kind == KIND_FROM_END) ? (SUM_W'(0) - total) : total;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        kind_next    = kind_reg;
        if (job_fire) begin
            m_valid_next = 1'b1;
            kind_next    = job.kind;
            if (job.kind == KIND_TIME || job.kind == KIND_FROM_END) begin
                value_next = $signed(signed_total[VALUE_W-1:0]);
            end else begin
                value_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        kind_reg  <= kind_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_time_value  = value_reg;
    assign m_result_kind = kind_reg;

endmodule

// File: hw/rtl/time_string_to_hundredths.sv
// Path: the parse of a text is registered in the finished-parse register, then in the result register.
// Throughput: one character per cycle while s_ready is high; the scanner state updates every transfer.
// The finished-parse register and the result register each hold one item, so
// s_ready drops only when both are full and m_ready is low.
// Reset: synchronous, active-low aresetn clears the parser state and both valids.
`include "time_string_to_hundredths_assert.svh"

module time_string_to_hundredths #(
    parameter int MINUTE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_char,
    input  logic                s_last_char,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [29:0]  m_time_value,
    output logic [1:0]          m_result_kind
);
    import tsh_pkg::*;

    logic                   job_valid;
    logic                   calc_ready;
    tsh_job_t               job;
    logic [MINUTE_BITS-1:0] job_minutes;

    tsh_scan #(
        .MINUTE_BITS (MINUTE_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_char (s_text_char),
        .s_last_char (s_last_char),
        .job_valid   (job_valid),
        .calc_ready  (calc_ready),
        .job         (job),
        .job_minutes (job_minutes)
    );

    tsh_calc #(
        .MINUTE_BITS (MINUTE_BITS)
    ) u_calc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .calc_ready    (calc_ready),
        .job           (job),
        .job_minutes   (job_minutes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_time_value  (m_time_value),
        .m_result_kind (m_result_kind)
    );

    `TSH_ASSERT_IMPL(a_zero_value_kinds, aclk, aresetn, m_valid && (m_result_kind == KIND_END_MARK || m_result_kind == KIND_INVALID), m_time_value == '0)
    `TSH_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn, !s_ready, job_valid && m_valid && !m_ready)
    `TSH_ASSERT_NEXT(a_job_held_on_stall, aclk, aresetn, job_valid && m_valid && !m_ready, job_valid)

endmodule
